[sv/lbgh_pkg.sv]
// Shared types, constants and the barrier term schedule of the log-barrier derivative core.
package lbgh_pkg;

   localparam int IN_W       = 32;
   localparam int IN_FIELDS  = 6;
   localparam int REQ_DATA_W = IN_W * IN_FIELDS;
   localparam int LIM_W      = 16;
   localparam int DEN_W      = 48;
   localparam int COEF_W     = 64;
   localparam int HX_W       = 64;
   localparam int H_W        = IN_W + 1;
   localparam int SLOPE_W    = 31;
   localparam int TT_W       = 46;
   localparam int TT_LO_W    = 23;
   localparam int TT_FULL_W  = 78;
   localparam int NUM_DEN    = 12;
   localparam int NUM_TERMS  = 36;
   localparam int TERM_CNT_W = 6;
   localparam int IDX_W      = 4;
   localparam int USER_W     = IDX_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [IDX_W-1:0] LAST_ENTRY = 4'd13;

   localparam logic [CSR_DATA_W-1:0] RST_INPUT_MIN    = 48'hFB00_F600_F600;
   localparam logic [CSR_DATA_W-1:0] RST_INPUT_MAX    = 48'h1400_0A00_0A00;
   localparam logic [IN_W-1:0]       RST_HEIGHT_MIN   = 32'hFFE7_0000;
   localparam logic [IN_W-1:0]       RST_HEIGHT_MAX   = 32'hFFF1_0000;
   localparam logic [SLOPE_W-1:0]    RST_SLOPE        = 31'h0000_8000;
   localparam logic [IN_W-1:0]       RST_STATE_WEIGHT = 32'h1999_999A;
   localparam logic [IN_W-1:0]       RST_INPUT_WEIGHT = 32'h0006_8DB9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INPUT_MIN    = 3'd0,
      CSR_INPUT_MAX    = 3'd1,
      CSR_HEIGHT_MIN   = 3'd2,
      CSR_HEIGHT_MAX   = 3'd3,
      CSR_SLOPE_X      = 3'd4,
      CSR_SLOPE_Y      = 3'd5,
      CSR_STATE_WEIGHT = 3'd6,
      CSR_INPUT_WEIGHT = 3'd7
   } csr_addr_type;

   typedef enum logic [2:0] {
      COEF_CU, COEF_CS, COEF_CTX, COEF_CTY, COEF_CTTX, COEF_CTTY
   } coef_sel_type;

   typedef enum logic [3:0] {
      DEN_UMAX0, DEN_UMAX1, DEN_UMAX2, DEN_UMIN0, DEN_UMIN1, DEN_UMIN2,
      DEN_DX1, DEN_DX2, DEN_DY1, DEN_DY2, DEN_ZMAX, DEN_ZMIN
   } den_sel_type;

   typedef struct packed {
      logic             grad;
      logic             sub;
      coef_sel_type     coef;
      den_sel_type      den;
      logic [IDX_W-1:0] entry;
      logic             first;
      logic             last;
   } term_type;

   typedef struct packed {
      logic             grad;
      logic             sub;
      logic             neg;
      logic             zero;
      logic [IDX_W-1:0] entry;
      logic             first;
      logic             last;
      logic [DEN_W-1:0] mag;
   } tag_type;

   function automatic term_type mk(logic grad, logic sub, coef_sel_type coef,
                                   den_sel_type den, logic [IDX_W-1:0] entry,
                                   logic first, logic last);
      term_type t;
      t.grad  = grad;
      t.sub   = sub;
      t.coef  = coef;
      t.den   = den;
      t.entry = entry;
      t.first = first;
      t.last  = last;
      return t;
   endfunction

   // one term per cycle while the rsp stream is not stalled; first/last frame the terms summed into one entry
   function automatic term_type term_of(logic [TERM_CNT_W-1:0] n);
      term_type t;
      case (n)
         6'd0:  t = mk(1'b1, 1'b0, COEF_CU,   DEN_UMAX0, 4'd0,  1'b1, 1'b0);
         6'd1:  t = mk(1'b1, 1'b1, COEF_CU,   DEN_UMIN0, 4'd0,  1'b0, 1'b1);
         6'd2:  t = mk(1'b1, 1'b0, COEF_CU,   DEN_UMAX1, 4'd1,  1'b1, 1'b0);
         6'd3:  t = mk(1'b1, 1'b1, COEF_CU,   DEN_UMIN1, 4'd1,  1'b0, 1'b1);
         6'd4:  t = mk(1'b1, 1'b0, COEF_CU,   DEN_UMAX2, 4'd2,  1'b1, 1'b0);
         6'd5:  t = mk(1'b1, 1'b1, COEF_CU,   DEN_UMIN2, 4'd2,  1'b0, 1'b1);
         6'd6:  t = mk(1'b1, 1'b0, COEF_CS,   DEN_DX1,   4'd3,  1'b1, 1'b0);
         6'd7:  t = mk(1'b1, 1'b1, COEF_CS,   DEN_DX2,   4'd3,  1'b0, 1'b1);
         6'd8:  t = mk(1'b1, 1'b0, COEF_CS,   DEN_DY1,   4'd4,  1'b1, 1'b0);
         6'd9:  t = mk(1'b1, 1'b1, COEF_CS,   DEN_DY2,   4'd4,  1'b0, 1'b1);
         6'd10: t = mk(1'b1, 1'b0, COEF_CS,   DEN_ZMAX,  4'd5,  1'b1, 1'b0);
         6'd11: t = mk(1'b1, 1'b1, COEF_CS,   DEN_ZMIN,  4'd5,  1'b0, 1'b0);
         6'd12: t = mk(1'b1, 1'b0, COEF_CTX,  DEN_DX1,   4'd5,  1'b0, 1'b0);
         6'd13: t = mk(1'b1, 1'b0, COEF_CTX,  DEN_DX2,   4'd5,  1'b0, 1'b0);
         6'd14: t = mk(1'b1, 1'b0, COEF_CTY,  DEN_DY1,   4'd5,  1'b0, 1'b0);
         6'd15: t = mk(1'b1, 1'b0, COEF_CTY,  DEN_DY2,   4'd5,  1'b0, 1'b1);
         6'd16: t = mk(1'b0, 1'b0, COEF_CU,   DEN_UMAX0, 4'd6,  1'b1, 1'b0);
         6'd17: t = mk(1'b0, 1'b0, COEF_CU,   DEN_UMIN0, 4'd6,  1'b0, 1'b1);
         6'd18: t = mk(1'b0, 1'b0, COEF_CU,   DEN_UMAX1, 4'd7,  1'b1, 1'b0);
         6'd19: t = mk(1'b0, 1'b0, COEF_CU,   DEN_UMIN1, 4'd7,  1'b0, 1'b1);
         6'd20: t = mk(1'b0, 1'b0, COEF_CU,   DEN_UMAX2, 4'd8,  1'b1, 1'b0);
         6'd21: t = mk(1'b0, 1'b0, COEF_CU,   DEN_UMIN2, 4'd8,  1'b0, 1'b1);
         6'd22: t = mk(1'b0, 1'b0, COEF_CS,   DEN_DX1,   4'd9,  1'b1, 1'b0);
         6'd23: t = mk(1'b0, 1'b0, COEF_CS,   DEN_DX2,   4'd9,  1'b0, 1'b1);
         6'd24: t = mk(1'b0, 1'b0, COEF_CS,   DEN_DY1,   4'd10, 1'b1, 1'b0);
         6'd25: t = mk(1'b0, 1'b0, COEF_CS,   DEN_DY2,   4'd10, 1'b0, 1'b1);
         6'd26: t = mk(1'b0, 1'b0, COEF_CS,   DEN_ZMAX,  4'd11, 1'b1, 1'b0);
         6'd27: t = mk(1'b0, 1'b0, COEF_CS,   DEN_ZMIN,  4'd11, 1'b0, 1'b0);
         6'd28: t = mk(1'b0, 1'b0, COEF_CTTX, DEN_DX1,   4'd11, 1'b0, 1'b0);
         6'd29: t = mk(1'b0, 1'b0, COEF_CTTX, DEN_DX2,   4'd11, 1'b0, 1'b0);
         6'd30: t = mk(1'b0, 1'b0, COEF_CTTY, DEN_DY1,   4'd11, 1'b0, 1'b0);
         6'd31: t = mk(1'b0, 1'b0, COEF_CTTY, DEN_DY2,   4'd11, 1'b0, 1'b1);
         6'd32: t = mk(1'b0, 1'b0, COEF_CTX,  DEN_DX1,   4'd12, 1'b1, 1'b0);
         6'd33: t = mk(1'b0, 1'b1, COEF_CTX,  DEN_DX2,   4'd12, 1'b0, 1'b1);
         6'd34: t = mk(1'b0, 1'b0, COEF_CTY,  DEN_DY1,   4'd13, 1'b1, 1'b0);
         6'd35: t = mk(1'b0, 1'b1, COEF_CTY,  DEN_DY2,   4'd13, 1'b0, 1'b1);
         default: t = mk(1'b0, 1'b0, COEF_CU, DEN_UMAX0, 4'd0, 1'b0, 1'b0);
      endcase
      return t;
   endfunction

endpackage

[sv/lbgh_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per stage, tag carried alongside.
module lbgh_div_pipe #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 48,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [TAG_W-1:0] tag_ff   [NUM_W];

   logic             valid_src [NUM_W];
   logic [DEN_W-1:0] rem_src   [NUM_W];
   logic [NUM_W-1:0] num_src   [NUM_W];
   logic [DEN_W-1:0] den_src   [NUM_W];
   logic [TAG_W-1:0] tag_src   [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0] shift;
      logic [DEN_W:0] diff;
      logic           ge;

      if (k == 0) begin : g_head
         assign valid_src[k] = in_valid;
         assign rem_src[k]   = '0;
         assign num_src[k]   = in_num;
         assign den_src[k]   = in_den;
         assign tag_src[k]   = in_tag;
      end else begin : g_body
         assign valid_src[k] = valid_ff[k-1];
         assign rem_src[k]   = rem_ff[k-1];
         assign num_src[k]   = num_ff[k-1];
         assign den_src[k]   = den_ff[k-1];
         assign tag_src[k]   = tag_ff[k-1];
      end

      assign shift = {rem_src[k], num_src[k][NUM_W-1]};
      assign diff  = shift - {1'b0, den_src[k]};
      assign ge    = (shift >= {1'b0, den_src[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DEN_W-1:0] : shift[DEN_W-1:0];
            num_ff[k] <= {num_src[k][NUM_W-2:0], ge};
            den_ff[k] <= den_src[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

[sv/log_barrier_grad_hess_core.sv]
// Log-barrier gradient and Hessian core for one MPC horizon stage.
// One req beat carries u1,u2,u3,x,y,z (Q16.16); the core answers with 14 rsp beats: the six
// gradient entries, then u1u1,u2u2,u3u3,xx,yy,zz,xz,yz, each saturated to Q16.16 with a flag.
// Every entry is a sum of barrier terms, 36 terms per stage, and a single pipelined divider
// chain (two 64-stage restoring dividers) takes one term per cycle while rsp is not stalled.
// A new stage is taken while the previous one is still in flight. A stalled rsp beat freezes
// the term sequencer, the divider chain and all stages after it; stages A and B can still fill.
// Coefficient registers settle after a csr write via ttx/tty, the partial products, then cttx/ctty.
module log_barrier_grad_hess_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // csr
   input  logic                                      csr_we,
   input  logic [lbgh_pkg::CSR_ADDR_W-1:0]           csr_addr,
   input  logic [lbgh_pkg::CSR_DATA_W-1:0]           csr_wdata,
   // req
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // in_u1, in_u2, in_u3, pos_x, pos_y, pos_z
   input  logic [lbgh_pkg::REQ_DATA_W-1:0]           req_tdata,
   // rsp
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // entry_value, zero padded to bytes
   output logic [((DATA_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   // entry_index, saturated
   output logic [lbgh_pkg::USER_W-1:0]               rsp_tuser,
   output logic                                      rsp_tlast
);

   import lbgh_pkg::*;

   localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int MAG_W   = DATA_WIDTH + 9;
   localparam int SUM_W   = DATA_WIDTH + 12;
   localparam int TAG_W   = $bits(tag_type);
   localparam logic [COEF_W-1:0] CAP = COEF_W'(1) << (DATA_WIDTH + 8);
   localparam logic signed [SUM_W-1:0] HI_S = (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] LO_S = -HI_S - SUM_W'(1);

   // csr registers
   logic [CSR_DATA_W-1:0]   imin_ff, imax_ff;
   logic signed [IN_W-1:0]  hmin_ff, hmax_ff;
   logic [SLOPE_W-1:0]      tx_ff, ty_ff;
   logic [IN_W-1:0]         ws_ff, wu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         imin_ff <= RST_INPUT_MIN;
         imax_ff <= RST_INPUT_MAX;
         hmin_ff <= RST_HEIGHT_MIN;
         hmax_ff <= RST_HEIGHT_MAX;
         tx_ff   <= RST_SLOPE;
         ty_ff   <= RST_SLOPE;
         ws_ff   <= RST_STATE_WEIGHT;
         wu_ff   <= RST_INPUT_WEIGHT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_INPUT_MIN:    imin_ff <= csr_wdata;
            CSR_INPUT_MAX:    imax_ff <= csr_wdata;
            CSR_HEIGHT_MIN:   hmin_ff <= csr_wdata[IN_W-1:0];
            CSR_HEIGHT_MAX:   hmax_ff <= csr_wdata[IN_W-1:0];
            CSR_SLOPE_X:      tx_ff   <= csr_wdata[SLOPE_W-1:0];
            CSR_SLOPE_Y:      ty_ff   <= csr_wdata[SLOPE_W-1:0];
            CSR_STATE_WEIGHT: ws_ff   <= csr_wdata[IN_W-1:0];
            CSR_INPUT_WEIGHT: wu_ff   <= csr_wdata[IN_W-1:0];
            default: ;
         endcase
      end
   end

   // coefficients, in units of 2^-48
   logic [COEF_W-1:0]    cu_ff, cs_ff, ctx_ff, cty_ff, cttx_ff, ctty_ff;
   logic [TT_W-1:0]      ttx_ff, tty_ff;
   logic [2*SLOPE_W-1:0] ttx_in, tty_in;
   logic [IN_W+TT_LO_W-1:0]        plx_ff, phx_ff, ply_ff, phy_ff;
   logic [TT_FULL_W-1:0]           fullx_in, fully_in;

   assign ttx_in   = tx_ff * tx_ff;
   assign tty_in   = ty_ff * ty_ff;
   assign fullx_in = (TT_FULL_W'(phx_ff) << TT_LO_W) + TT_FULL_W'(plx_ff);
   assign fully_in = (TT_FULL_W'(phy_ff) << TT_LO_W) + TT_FULL_W'(ply_ff);

   always_ff @(posedge clock) begin
      cu_ff   <= COEF_W'({wu_ff, 16'h0000});
      cs_ff   <= COEF_W'({ws_ff, 16'h0000});
      ctx_ff  <= COEF_W'(ws_ff * tx_ff);
      cty_ff  <= COEF_W'(ws_ff * ty_ff);
      ttx_ff  <= ttx_in[TT_W+15:16];
      tty_ff  <= tty_in[TT_W+15:16];
      plx_ff  <= ws_ff * ttx_ff[TT_LO_W-1:0];
      phx_ff  <= ws_ff * ttx_ff[TT_W-1:TT_LO_W];
      ply_ff  <= ws_ff * tty_ff[TT_LO_W-1:0];
      phy_ff  <= ws_ff * tty_ff[TT_W-1:TT_LO_W];
      cttx_ff <= (|fullx_in[TT_FULL_W-1:COEF_W-1]) ? {1'b0, {(COEF_W-1){1'b1}}}
                                                   : COEF_W'(fullx_in[COEF_W-2:0]);
      ctty_ff <= (|fully_in[TT_FULL_W-1:COEF_W-1]) ? {1'b0, {(COEF_W-1){1'b1}}}
                                                   : COEF_W'(fully_in[COEF_W-2:0]);
   end

   // pipeline control
   logic pipe_en;
   logic a_ready, b_ready, seq_free;
   logic a_v_ff, b_v_ff, seq_busy_ff;
   logic [TERM_CNT_W-1:0] cnt_ff;

   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign seq_free   = !seq_busy_ff || (cnt_ff == TERM_CNT_W'(NUM_TERMS - 1) && pipe_en);
   assign b_ready    = !b_v_ff || seq_free;
   assign a_ready    = !a_v_ff || b_ready;
   assign req_tready = a_ready;

   // stage A: captured beat
   logic signed [IN_W-1:0] a_u_ff [3];
   logic signed [IN_W-1:0] a_x_ff, a_y_ff, a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_ready) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && a_ready) begin
         for (int i = 0; i < 3; i++) begin
            a_u_ff[i] <= req_tdata[IN_W*i +: IN_W];
         end
         a_x_ff <= req_tdata[IN_W*3 +: IN_W];
         a_y_ff <= req_tdata[IN_W*4 +: IN_W];
         a_z_ff <= req_tdata[IN_W*5 +: IN_W];
      end
   end

   // stage B: box distances, cone products
   logic signed [DEN_W-1:0] umin_w [3];
   logic signed [DEN_W-1:0] umax_w [3];
   logic signed [DEN_W-1:0] dmax_in [3];
   logic signed [DEN_W-1:0] dmin_in [3];
   logic signed [H_W-1:0]   h_w;
   logic signed [HX_W-1:0]  hx_in, hy_in;
   logic signed [DEN_W-1:0] dzx_in, dzn_in;

   logic signed [DEN_W-1:0] b_dmax_ff [3];
   logic signed [DEN_W-1:0] b_dmin_ff [3];
   logic signed [HX_W-1:0]  b_hx_ff, b_hy_ff;
   logic signed [DEN_W-1:0] b_dzx_ff, b_dzn_ff;
   logic signed [IN_W-1:0]  b_x_ff, b_y_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         umin_w[i]  = DEN_W'(signed'(imin_ff[LIM_W*i +: LIM_W])) <<< 8;
         umax_w[i]  = DEN_W'(signed'(imax_ff[LIM_W*i +: LIM_W])) <<< 8;
         dmax_in[i] = umax_w[i] - DEN_W'(a_u_ff[i]);
         dmin_in[i] = DEN_W'(a_u_ff[i]) - umin_w[i];
      end
      h_w    = -H_W'(a_z_ff);
      hx_in  = h_w * signed'({1'b0, tx_ff});
      hy_in  = h_w * signed'({1'b0, ty_ff});
      dzx_in = DEN_W'(hmax_ff) - DEN_W'(a_z_ff);
      dzn_in = DEN_W'(a_z_ff) - DEN_W'(hmin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_ready) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_v_ff) begin
         b_dmax_ff <= dmax_in;
         b_dmin_ff <= dmin_in;
         b_hx_ff   <= hx_in;
         b_hy_ff   <= hy_in;
         b_dzx_ff  <= dzx_in;
         b_dzn_ff  <= dzn_in;
         b_x_ff    <= a_x_ff;
         b_y_ff    <= a_y_ff;
      end
   end

   // term sequencer: holds the twelve denominators of the stage in flight
   logic signed [DEN_W-1:0] htx_w, hty_w;
   logic signed [DEN_W-1:0] den_ff [NUM_DEN];

   assign htx_w = signed'(b_hx_ff[DEN_W+15:16]);
   assign hty_w = signed'(b_hy_ff[DEN_W+15:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
         cnt_ff      <= '0;
      end else if (seq_free) begin
         seq_busy_ff <= b_v_ff;
         cnt_ff      <= '0;
      end else if (pipe_en) begin
         cnt_ff <= cnt_ff + TERM_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (seq_free && b_v_ff) begin
         for (int i = 0; i < 3; i++) begin
            den_ff[i]     <= b_dmax_ff[i];
            den_ff[i + 3] <= b_dmin_ff[i];
         end
         den_ff[6]  <= htx_w - DEN_W'(b_x_ff);
         den_ff[7]  <= htx_w + DEN_W'(b_x_ff);
         den_ff[8]  <= hty_w - DEN_W'(b_y_ff);
         den_ff[9]  <= hty_w + DEN_W'(b_y_ff);
         den_ff[10] <= b_dzx_ff;
         den_ff[11] <= b_dzn_ff;
      end
   end

   // issue stage
   term_type                term_w;
   logic signed [DEN_W-1:0] den_pick;
   logic [COEF_W-1:0]       coef_pick;

   assign term_w = term_of(cnt_ff);

   always_comb begin
      case (term_w.den)
         DEN_UMAX0: den_pick = den_ff[0];
         DEN_UMAX1: den_pick = den_ff[1];
         DEN_UMAX2: den_pick = den_ff[2];
         DEN_UMIN0: den_pick = den_ff[3];
         DEN_UMIN1: den_pick = den_ff[4];
         DEN_UMIN2: den_pick = den_ff[5];
         DEN_DX1:   den_pick = den_ff[6];
         DEN_DX2:   den_pick = den_ff[7];
         DEN_DY1:   den_pick = den_ff[8];
         DEN_DY2:   den_pick = den_ff[9];
         DEN_ZMAX:  den_pick = den_ff[10];
         DEN_ZMIN:  den_pick = den_ff[11];
         default:   den_pick = den_ff[0];
      endcase
      case (term_w.coef)
         COEF_CU:   coef_pick = cu_ff;
         COEF_CS:   coef_pick = cs_ff;
         COEF_CTX:  coef_pick = ctx_ff;
         COEF_CTY:  coef_pick = cty_ff;
         COEF_CTTX: coef_pick = cttx_ff;
         COEF_CTTY: coef_pick = ctty_ff;
         default:   coef_pick = cu_ff;
      endcase
   end

   logic                    iss_v_ff;
   term_type                iss_term_ff;
   logic signed [DEN_W-1:0] iss_den_ff;
   logic [COEF_W-1:0]       iss_coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_v_ff <= 1'b0;
      end else if (pipe_en) begin
         iss_v_ff <= seq_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         iss_term_ff <= term_w;
         iss_den_ff  <= den_pick;
         iss_coef_ff <= coef_pick;
      end
   end

   // divider chain: grad c/(|d|<<16) = (c>>16)/|d|, hess (c/|d|)/|d|
   tag_type           tag1_in, tag1_out, tag2_out;
   logic [TAG_W-1:0]  tag1_vec, tag2_vec;
   logic [COEF_W-1:0] num1_in, q1, q2;
   logic [DEN_W-1:0]  den2_in;
   logic              v1, v2;

   always_comb begin
      tag1_in.grad  = iss_term_ff.grad;
      tag1_in.sub   = iss_term_ff.sub;
      tag1_in.neg   = iss_term_ff.grad && iss_den_ff[DEN_W-1];
      tag1_in.zero  = (iss_den_ff == '0);
      tag1_in.entry = iss_term_ff.entry;
      tag1_in.first = iss_term_ff.first;
      tag1_in.last  = iss_term_ff.last;
      tag1_in.mag   = iss_den_ff[DEN_W-1] ? DEN_W'(-iss_den_ff) : DEN_W'(iss_den_ff);
      num1_in       = iss_term_ff.grad ? (iss_coef_ff >> 16) : iss_coef_ff;
   end

   lbgh_div_pipe #(.NUM_W(COEF_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_first (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (iss_v_ff),
      .in_num    (num1_in),
      .in_den    (tag1_in.mag),
      .in_tag    (TAG_W'(tag1_in)),
      .out_valid (v1),
      .out_quo   (q1),
      .out_tag   (tag1_vec)
   );

   assign tag1_out = tag_type'(tag1_vec);
   assign den2_in  = tag1_out.grad ? DEN_W'(1) : tag1_out.mag;

   lbgh_div_pipe #(.NUM_W(COEF_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_second (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v1),
      .in_num    (q1),
      .in_den    (den2_in),
      .in_tag    (tag1_vec),
      .out_valid (v2),
      .out_quo   (q2),
      .out_tag   (tag2_vec)
   );

   assign tag2_out = tag_type'(tag2_vec);

   // clamp and sign one term
   logic [MAG_W-1:0]        mag_w;
   logic signed [SUM_W-1:0] trm_in;
   logic                    trm_v_ff;
   logic signed [SUM_W-1:0] trm_ff;
   tag_type                 trm_tag_ff;

   assign mag_w  = (q2 > CAP) ? CAP[MAG_W-1:0] : q2[MAG_W-1:0];
   assign trm_in = (tag2_out.neg ^ tag2_out.sub) ? -SUM_W'(mag_w) : SUM_W'(mag_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         trm_v_ff <= 1'b0;
      end else if (pipe_en) begin
         trm_v_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         trm_ff     <= trm_in;
         trm_tag_ff <= tag2_out;
      end
   end

   // accumulate terms of one entry
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                    acc_zero_ff, acc_zero_in;
   logic                    fin_v_ff;
   logic signed [SUM_W-1:0] fin_sum_ff;
   logic                    fin_zero_ff;
   logic [IDX_W-1:0]        fin_entry_ff;

   assign acc_in      = trm_tag_ff.first ? trm_ff : acc_ff + trm_ff;
   assign acc_zero_in = trm_tag_ff.zero || (!trm_tag_ff.first && acc_zero_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (pipe_en) begin
         fin_v_ff <= trm_v_ff && trm_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && trm_v_ff) begin
         acc_ff       <= acc_in;
         acc_zero_ff  <= acc_zero_in;
         fin_sum_ff   <= acc_in;
         fin_zero_ff  <= acc_zero_in;
         fin_entry_ff <= trm_tag_ff.entry;
      end
   end

   // output register with saturation
   logic                    rsp_v_ff;
   logic [DATA_WIDTH-1:0]   rsp_value_ff;
   logic                    rsp_sat_ff, rsp_last_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic signed [SUM_W-1:0] sat_w;
   logic                    sat_flag;

   always_comb begin
      sat_w    = fin_sum_ff;
      sat_flag = 1'b0;
      if (fin_zero_ff || fin_sum_ff > HI_S) begin
         sat_w    = HI_S;
         sat_flag = 1'b1;
      end else if (fin_sum_ff < LO_S) begin
         sat_w    = LO_S;
         sat_flag = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_v_ff <= fin_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && fin_v_ff) begin
         rsp_value_ff <= sat_w[DATA_WIDTH-1:0];
         rsp_sat_ff   <= sat_flag;
         rsp_idx_ff   <= fin_entry_ff;
         rsp_last_ff  <= (fin_entry_ff == LAST_ENTRY);
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = TDATA_W'(rsp_value_ff);
   assign rsp_tuser  = {rsp_sat_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[sv/lbgh_chk.sv]
// Port-level checks on the rsp stream of the core, with its bind.
module lbgh_chk #(
   parameter int DATA_WIDTH = 32
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((DATA_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   input logic [lbgh_pkg::USER_W-1:0]          rsp_tuser,
   input logic                                 rsp_tlast
);

   import lbgh_pkg::*;

   localparam logic [DATA_WIDTH-1:0] VAL_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] VAL_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [IDX_W-1:0] exp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         exp_idx_ff <= (rsp_tuser[IDX_W-1:0] == LAST_ENTRY) ? '0
                                                            : rsp_tuser[IDX_W-1:0] + IDX_W'(1);
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[IDX_W-1:0] == exp_idx_ff)
      else $error("rsp entry out of order");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser[IDX_W-1:0] == LAST_ENTRY))
      else $error("tlast not on final entry");

   a_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[IDX_W] |->
         rsp_tdata[DATA_WIDTH-1:0] == VAL_HI || rsp_tdata[DATA_WIDTH-1:0] == VAL_LO)
      else $error("saturated beat not at a rail");

endmodule

bind log_barrier_grad_hess_core lbgh_chk #(.DATA_WIDTH(DATA_WIDTH)) u_lbgh_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
